/* sv/dte_pkg.sv */
// ----------------------------------------------------------------------------
// dte_pkg
// shared types, constants and the gcr table for the dshot telemetry encoder
// ----------------------------------------------------------------------------
package dte_pkg;

    localparam int unsigned PulseW   = 16;
    localparam int unsigned ValueW   = 16;
    localparam int unsigned MantW    = 9;
    localparam int unsigned ExpW     = 3;
    localparam int unsigned PayW     = 12;
    localparam int unsigned GcrW     = 20;
    localparam int unsigned LineW    = GcrW + 1;
    localparam int unsigned Slots    = 22;
    localparam int unsigned SlotW    = $clog2(Slots);
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam int unsigned QCntW    = $clog2(QDepth + 1);

    localparam logic [SlotW-1:0] LastSlot = SlotW'(Slots - 1);
    localparam logic [QCntW-1:0] QFull    = QCntW'(QDepth);

    localparam logic FuncPack  = 1'b0;
    localparam logic FuncReady = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ValueW-1:0] payload_value;
    } t_req;

    typedef struct packed {
        logic [PulseW-1:0] pulse_width;
        logic              line_bit;
        logic              last;
    } t_res;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    function automatic logic [4:0] gcr_map(input logic [3:0] nib);
        logic [4:0] code;
        case (nib)
            4'h0:    code = 5'h19;
            4'h1:    code = 5'h1B;
            4'h2:    code = 5'h12;
            4'h3:    code = 5'h13;
            4'h4:    code = 5'h1D;
            4'h5:    code = 5'h15;
            4'h6:    code = 5'h16;
            4'h7:    code = 5'h17;
            4'h8:    code = 5'h1A;
            4'h9:    code = 5'h09;
            4'hA:    code = 5'h0A;
            4'hB:    code = 5'h0B;
            4'hC:    code = 5'h1E;
            4'hD:    code = 5'h0D;
            4'hE:    code = 5'h0E;
            4'hF:    code = 5'h0F;
            default: code = 5'h19;
        endcase
        return code;
    endfunction

endpackage

/* sv/dshot_telemetry_encoder.sv */
// ----------------------------------------------------------------------------
// dshot_telemetry_encoder
// bidirectional dshot gcr telemetry frame encoder
// ----------------------------------------------------------------------------
// usage:
//   a request (func, payload_value) is taken at a clock edge with start high
//   and busy low. func 0 packs a period into exponent and mantissa, func 1
//   sends the low 12 bits as they are. the block adds the checksum, gcr and
//   nrzi codes the frame and emits 22 results on o_res, one per cycle, each
//   marked by o_strobe for one cycle; the last one has last set.
//   results of consecutive frames follow with no gap when the next is queued.
//   a two-entry queue sits between the encoder and the serializer, so busy
//   rises only when two frames wait behind the one being sent. the user must
//   see that the width register is written with i_cfg_we and i_cfg_wdata only
//   while idle; the block does not enforce it. reset clears the queue, the
//   serializer and the width register. the receiver cannot hold results off;
//   every result is shown once.
// ----------------------------------------------------------------------------
module dshot_telemetry_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dte_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [dte_pkg::PulseW-1:0]    i_cfg_wdata,
    output logic                          o_strobe,
    output dte_pkg::t_res                 o_res
);
    import dte_pkg::*;

    logic [PulseW-1:0] r_bit_pulse_width;
    logic [LineW-1:0]  front_line;
    logic [LineW-1:0]  q_line;
    t_q_stat           q_stat;
    logic              push;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pulse_width <= '0;
        end else if (i_cfg_we) begin
            r_bit_pulse_width <= i_cfg_wdata;
        end
    end

    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    dte_front u_front (
        .i_req  (i_req),
        .o_line (front_line)
    );

    dte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_line),
        .i_pop   (pop),
        .o_data  (q_line),
        .o_stat  (q_stat)
    );

    dte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (q_stat),
        .i_line        (q_line),
        .i_pulse_width (r_bit_pulse_width),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_res         (o_res)
    );

endmodule

/* sv/dte_front.sv */
// ----------------------------------------------------------------------------
// dte_front
// classifies a request, packs the payload, adds the checksum and builds the
// nrzi line word
// ----------------------------------------------------------------------------
module dte_front (
    input  dte_pkg::t_req                 i_req,
    output logic [dte_pkg::LineW-1:0]     o_line
);
    import dte_pkg::*;

    logic [ExpW-1:0]   exp_c;
    logic [ValueW-1:0] shifted;
    logic [PayW-1:0]   pay;
    logic [3:0]        chk;
    logic [15:0]       frame;
    logic [GcrW-1:0]   gcr;

    always_comb begin
        if (i_req.payload_value[15]) begin
            exp_c = 3'd7;
        end else if (i_req.payload_value[14]) begin
            exp_c = 3'd6;
        end else if (i_req.payload_value[13]) begin
            exp_c = 3'd5;
        end else if (i_req.payload_value[12]) begin
            exp_c = 3'd4;
        end else if (i_req.payload_value[11]) begin
            exp_c = 3'd3;
        end else if (i_req.payload_value[10]) begin
            exp_c = 3'd2;
        end else if (i_req.payload_value[9]) begin
            exp_c = 3'd1;
        end else begin
            exp_c = 3'd0;
        end
    end

    assign shifted = i_req.payload_value >> exp_c;

    always_comb begin
        case (i_req.func)
            FuncPack:  pay = {exp_c, shifted[MantW-1:0]};
            FuncReady: pay = i_req.payload_value[PayW-1:0];
            default:   pay = i_req.payload_value[PayW-1:0];
        endcase
    end

    assign chk   = ~(pay[3:0] ^ pay[7:4] ^ pay[11:8]);
    assign frame = {pay, chk};
    assign gcr   = {gcr_map(frame[15:12]), gcr_map(frame[11:8]),
                    gcr_map(frame[7:4]), gcr_map(frame[3:0])};

    // each line bit is the running parity of the gcr code from the top
    always_comb begin
        o_line[GcrW] = 1'b0;
        for (int b = 0; b < GcrW; b++) begin
            o_line[b] = ^(gcr >> b);
        end
    end

endmodule

/* sv/dte_queue.sv */
// ----------------------------------------------------------------------------
// dte_queue
// short fifo of encoded line words between the front and the serializer
// ----------------------------------------------------------------------------
module dte_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [dte_pkg::LineW-1:0]     i_data,
    input  logic                          i_pop,
    output logic [dte_pkg::LineW-1:0]     o_data,
    output dte_pkg::t_q_stat              o_stat
);
    import dte_pkg::*;

    logic [LineW-1:0] r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr, n_wptr;
    logic [QPtrW-1:0] r_rptr, n_rptr;
    logic [QCntW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPtrW'(QDepth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPtrW'(QDepth - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data           = r_mem[r_rptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == QFull);

endmodule

/* sv/dte_back.sv */
// ----------------------------------------------------------------------------
// dte_back
// serializes one line word into 22 pulse width results, one per cycle
// ----------------------------------------------------------------------------
module dte_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dte_pkg::t_q_stat              i_stat,
    input  logic [dte_pkg::LineW-1:0]     i_line,
    input  logic [dte_pkg::PulseW-1:0]    i_pulse_width,
    output logic                          o_pop,
    output logic                          o_strobe,
    output dte_pkg::t_res                 o_res
);
    import dte_pkg::*;

    logic             r_act, n_act;
    logic [SlotW-1:0] r_slot, n_slot;
    logic [LineW-1:0] r_line, n_line;
    logic             r_strobe;
    t_res             r_res, n_res;
    logic             slot_last;

    assign slot_last = (r_slot == LastSlot);
    assign o_pop     = i_stat.not_empty && (!r_act || slot_last);

    always_comb begin
        n_act  = r_act;
        n_slot = r_slot;
        n_line = r_line;
        if (o_pop) begin
            n_act  = 1'b1;
            n_slot = '0;
            n_line = i_line;
        end else if (r_act) begin
            n_act  = !slot_last;
            n_slot = r_slot + 1'b1;
            n_line = {r_line[LineW-2:0], 1'b0};
        end
    end

    always_comb begin
        n_res.last        = slot_last;
        n_res.line_bit    = slot_last ? 1'b0 : r_line[LineW-1];
        n_res.pulse_width = (slot_last || r_line[LineW-1]) ? '0 : i_pulse_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_slot   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_slot   <= n_slot;
            r_strobe <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
        r_res  <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* sv/dte_checker.sv */
// ----------------------------------------------------------------------------
// dte_checker
// port-level checks on the result stream of the telemetry encoder
// ----------------------------------------------------------------------------
module dte_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_strobe,
    input  dte_pkg::t_res  o_res
);
    import dte_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    a_high_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.line_bit) |-> (o_res.pulse_width == '0))
        else $error("high line bit with nonzero width");

    a_trailing_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |-> (!o_res.line_bit && o_res.pulse_width == '0))
        else $error("trailing slot not empty");

    a_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (!o_res.line_bit && !o_res.last))
        else $error("frame does not open with a low line bit");

endmodule

bind dshot_telemetry_encoder dte_checker u_dte_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

/* tb/tb_dshot_telemetry_encoder.sv */
// ----------------------------------------------------------------------------
// tb_dshot_telemetry_encoder
// self-checking bench for the dshot telemetry frame encoder. a short table of
// directed requests is run first, followed by random requests in phases that
// each use a different pulse width. every result slot is checked in order
// against a table line word or a predictor (packing, checksum, gcr and nrzi).
// ----------------------------------------------------------------------------
module tb_dshot_telemetry_encoder;
    import dte_pkg::*;

    localparam int IdleLimit   = 2000;
    localparam int MaxReport   = 10;
    localparam int NumDir      = 22;
    localparam int NumPhase    = 8;
    localparam int PhaseReqs   = 48;
    localparam int DrainCycles = 8;

    localparam logic [4:0] GcrCode [16] = '{
        5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
        5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F
    };

    typedef enum logic {ROW_REQ, ROW_WIDTH} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              func;
        logic [ValueW-1:0] value;
        logic              typed;
        logic [LineW-1:0]  line;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_req              i_req       = '0;
    logic              i_cfg_we    = 1'b0;
    logic [PulseW-1:0] i_cfg_wdata = '0;
    logic              o_strobe;
    t_res              o_res;

    logic [PulseW-1:0] width_model = '0;
    t_res              slot_q [$];
    int                err_cnt     = 0;
    int                idle_cyc    = 0;
    logic              no_idle     = 1'b0;

    // line words for the extremes: payload 0 and payload 0xfff
    t_dir_row dir_tab [NumDir] = '{
        '{ROW_REQ,   FuncReady, 16'h0000, 1'b1, 21'h08BA35},
        '{ROW_REQ,   FuncPack,  16'h0000, 1'b1, 21'h08BA35},
        '{ROW_REQ,   FuncReady, 16'h0FFF, 1'b1, 21'h052951},
        '{ROW_REQ,   FuncPack,  16'hFFFF, 1'b1, 21'h052951},
        '{ROW_REQ,   FuncReady, 16'hF000, 1'b1, 21'h08BA35},
        '{ROW_REQ,   FuncReady, 16'hFFFF, 1'b1, 21'h052951},
        '{ROW_WIDTH, FuncPack,  16'hFFFF, 1'b0, 21'h0},
        '{ROW_REQ,   FuncReady, 16'h0000, 1'b1, 21'h08BA35},
        '{ROW_REQ,   FuncPack,  16'hFFFF, 1'b1, 21'h052951},
        '{ROW_REQ,   FuncPack,  16'h01FF, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h0200, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h0400, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h0800, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h1000, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h2000, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h4000, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h8000, 1'b0, 21'h0},
        '{ROW_REQ,   FuncReady, 16'h0A5A, 1'b0, 21'h0},
        '{ROW_REQ,   FuncReady, 16'h05A5, 1'b0, 21'h0},
        '{ROW_WIDTH, FuncPack,  16'h1234, 1'b0, 21'h0},
        '{ROW_REQ,   FuncPack,  16'h0001, 1'b0, 21'h0},
        '{ROW_REQ,   FuncReady, 16'h0800, 1'b0, 21'h0}
    };

    logic [PulseW-1:0] phase_width [NumPhase] = '{
        16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h5A5A, 16'hA5A5, 16'h0000, 16'h0000
    };

    dshot_telemetry_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LineW-1:0] frame_line(input logic func,
                                                    input logic [ValueW-1:0] value);
        logic [ValueW-1:0] v;
        logic [ExpW-1:0]   e;
        logic [PayW-1:0]   pay;
        logic [3:0]        chk;
        logic [15:0]       frame;
        logic [GcrW-1:0]   gcr;
        logic [LineW-1:0]  line;
        int                b;
        v = value;
        e = '0;
        if (func == FuncPack) begin
            while (v[15:9] != '0) begin
                v = v >> 1;
                e = e + 3'd1;
            end
            pay = {e, v[8:0]};
        end else begin
            pay = value[PayW-1:0];
        end
        chk   = ~(pay[3:0] ^ pay[7:4] ^ pay[11:8]);
        frame = {pay, chk};
        gcr   = {GcrCode[frame[15:12]], GcrCode[frame[11:8]],
                 GcrCode[frame[7:4]], GcrCode[frame[3:0]]};
        line[20] = 1'b0;
        for (b = 19; b >= 0; b--)
            line[b] = line[b+1] ^ gcr[b];
        return line;
    endfunction

    function automatic void push_slots(input logic [LineW-1:0] line);
        t_res s;
        int   k;
        for (k = 0; k < Slots - 1; k++) begin
            s.line_bit    = line[20-k];
            s.pulse_width = s.line_bit ? '0 : width_model;
            s.last        = 1'b0;
            slot_q.push_back(s);
        end
        s.pulse_width = '0;
        s.line_bit    = 1'b0;
        s.last        = 1'b1;
        slot_q.push_back(s);
    endfunction

    task automatic set_width(input logic [PulseW-1:0] w);
        start <= 1'b0;
        while (slot_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        width_model = w;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input t_req r, input logic typed,
                                input logic [LineW-1:0] line);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 6);
        else
            gap = $urandom_range(7, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        push_slots(typed ? line : frame_line(r.func, r.payload_value));
    endtask

    always @(posedge i_clk) begin : mon
        t_res want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (slot_q.size() == 0) begin
                if (err_cnt < MaxReport)
                    $display("unexpected slot: pw=%h lb=%b last=%b",
                             o_res.pulse_width, o_res.line_bit, o_res.last);
                err_cnt++;
            end else begin
                want = slot_q.pop_front();
                if (o_res.pulse_width !== want.pulse_width ||
                    o_res.line_bit !== want.line_bit || o_res.last !== want.last) begin
                    if (err_cnt < MaxReport)
                        $display("slot mismatch: exp pw=%h lb=%b last=%b got pw=%h lb=%b last=%b",
                                 want.pulse_width, want.line_bit, want.last,
                                 o_res.pulse_width, o_res.line_bit, o_res.last);
                    err_cnt++;
                end
            end
        end
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1)
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IdleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stim
        t_req r;
        int   i;
        int   p;
        int   n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < NumDir; i++) begin
            if (dir_tab[i].kind == ROW_WIDTH) begin
                set_width(dir_tab[i].value);
            end else begin
                r.func          = dir_tab[i].func;
                r.payload_value = dir_tab[i].value;
                send_request(r, dir_tab[i].typed, dir_tab[i].line);
            end
        end

        for (p = 0; p < NumPhase; p++) begin
            set_width(p < 6 ? phase_width[p] : 16'($urandom));
            // back-to-back bursts to fill the queue and hold busy
            no_idle = (p == 3) || (p == 6);
            for (n = 0; n < PhaseReqs; n++) begin
                r.func          = 1'($urandom_range(0, 1));
                r.payload_value = 16'($urandom) &
                                  16'((32'h1 << $urandom_range(1, 16)) - 1);
                send_request(r, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (slot_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
sv/dte_pkg.sv
sv/dte_front.sv
sv/dte_queue.sv
sv/dte_back.sv
sv/dshot_telemetry_encoder.sv
sv/dte_checker.sv
tb/tb_dshot_telemetry_encoder.sv
